### design/grev_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package grev_pkg;

    // Field widths fixed by the interface definition
    localparam int VALUE_W = 32;
    localparam int GS_W    = 5;

    // Reset value of the group size register
    localparam logic [GS_W-1:0] GS_RESET = 5'd1;

    // Sequencer status seen by the top level
    typedef struct packed {
        logic emitting;   // a group is being read out of the buffer
        logic rd_issue;   // a buffer read is issued this cycle
    } status_t;

endpackage : grev_pkg

`default_nettype wire

### design/grev_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface grev_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [grev_pkg::VALUE_W-1:0]  value;
    logic                                 final_item;

    modport source (output valid, output value, output final_item, input ready);
    modport sink   (input valid, input value, input final_item, output ready);
endinterface : grev_in_if

`default_nettype wire

### design/grev_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface grev_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [grev_pkg::VALUE_W-1:0]  value_out;
    logic                                 run_end;
    logic                                 stream_end;

    modport source (output valid, output value_out, output run_end, output stream_end,
                    input ready);
    modport sink   (input valid, input value_out, input run_end, input stream_end,
                    output ready);
endinterface : grev_out_if

`default_nettype wire

### design/grev_mem.sv
`timescale 1ns / 1ps
`default_nettype none

// Group buffer: one write port, one read port, registered read data.
// The read data register doubles as the output data register.
module grev_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  wire logic                         clk,
    input  wire logic                         we,
    input  wire logic [AW-1:0]                waddr,
    input  wire logic [grev_pkg::VALUE_W-1:0] wdata,
    input  wire logic                         re,
    input  wire logic [AW-1:0]                raddr,
    output logic      [grev_pkg::VALUE_W-1:0] rdata
);

    logic [grev_pkg::VALUE_W-1:0] mem [DEPTH];
    logic [grev_pkg::VALUE_W-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, data held while no read is issued
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule : grev_mem

`default_nettype wire

### design/grev_seq.sv
`timescale 1ns / 1ps
`default_nettype none

// Sequencer: fill count, group size register, emission pointer and
// output flag registers.
module grev_seq #(
    parameter int MAX_GROUP = 16,
    parameter int AW        = 4,
    parameter int CW        = 5
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // configuration
    input  wire logic                        cfg_we,
    input  wire logic [grev_pkg::GS_W-1:0]   cfg_data,
    // input side handshake
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic                        in_final,
    // output side handshake and flags
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic                             out_run_end,
    output logic                             out_stream_end,
    // buffer ports
    output logic                             mem_we,
    output logic [AW-1:0]                    mem_waddr,
    output logic                             mem_re,
    output logic [AW-1:0]                    mem_raddr,
    // status
    output grev_pkg::status_t                status
);

    localparam int KW = (CW > grev_pkg::GS_W) ? CW : grev_pkg::GS_W;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic                      state_reg, state_next;
    logic [grev_pkg::GS_W-1:0] gs_reg;
    logic [CW-1:0]             fill_reg, fill_next;
    logic [AW-1:0]             rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]             left_reg, left_next;
    logic                      rev_reg, rev_next;
    logic                      last_reg, last_next;
    logic                      out_valid_reg, out_valid_next;
    logic                      run_end_reg, run_end_next;
    logic                      stream_end_reg, stream_end_next;

    logic [KW-1:0] gs_ext;
    logic [KW-1:0] k_eff;
    logic [KW-1:0] n_ext;
    logic          in_fire;
    logic          rd_en;
    logic          last_read;

    // Effective group size: zero counts as one, saturate at MAX_GROUP
    always_comb
    begin
        gs_ext = KW'(gs_reg);
        if (gs_ext == '0)
        begin
            k_eff = KW'(1);
        end
        else if (gs_ext > KW'(MAX_GROUP))
        begin
            k_eff = KW'(MAX_GROUP);
        end
        else
        begin
            k_eff = gs_ext;
        end
    end

    assign n_ext     = KW'(fill_reg) + KW'(1);
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign rd_en     = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);
    assign last_read = (left_reg == CW'(1));

    // Next-state logic
    always_comb
    begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        rd_ptr_next     = rd_ptr_reg;
        left_next       = left_reg;
        rev_next        = rev_reg;
        last_next       = last_reg;
        out_valid_next  = out_valid_reg;
        run_end_next    = run_end_reg;
        stream_end_next = stream_end_reg;

        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    last_next = in_final;
                    left_next = CW'(n_ext);
                    if (n_ext >= k_eff)
                    begin
                        // full group (or more after a size change): newest first
                        state_next  = ST_EMIT;
                        rev_next    = 1'b1;
                        rd_ptr_next = fill_reg[AW-1:0];
                        fill_next   = '0;
                    end
                    else if (in_final)
                    begin
                        // partial group at end of list: arrival order
                        state_next  = ST_EMIT;
                        rev_next    = 1'b0;
                        rd_ptr_next = '0;
                        fill_next   = '0;
                    end
                    else
                    begin
                        fill_next = CW'(n_ext);
                    end
                end
            end
            ST_EMIT:
            begin
                if (rd_en)
                begin
                    out_valid_next  = 1'b1;
                    run_end_next    = last_read;
                    stream_end_next = last_read && last_reg;
                    left_next       = left_reg - CW'(1);
                    rd_ptr_next     = rev_reg ? (rd_ptr_reg - AW'(1))
                                              : (rd_ptr_reg + AW'(1));
                    if (last_read)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            gs_reg        <= grev_pkg::GS_RESET;
            fill_reg      <= '0;
            left_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            left_reg      <= left_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                gs_reg <= cfg_data;
            end
        end
    end

    // Pointer and flag registers
    always_ff @(posedge clk)
    begin
        rd_ptr_reg     <= rd_ptr_next;
        rev_reg        <= rev_next;
        last_reg       <= last_next;
        run_end_reg    <= run_end_next;
        stream_end_reg <= stream_end_next;
    end

    assign mem_we    = in_fire;
    assign mem_waddr = fill_reg[AW-1:0];
    assign mem_re    = rd_en;
    assign mem_raddr = rd_ptr_reg;

    assign out_valid      = out_valid_reg;
    assign out_run_end    = run_end_reg;
    assign out_stream_end = stream_end_reg;

    assign status.emitting = (state_reg == ST_EMIT);
    assign status.rd_issue = rd_en;

endmodule : grev_seq

`default_nettype wire

### design/group_order_reverser_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Dir | Fields                              | Transaction
// ----------+-----+-------------------------------------+---------------------------
// items     | in  | value[31:0] s, final_item           | valid & ready
// results   | out | value_out[31:0] s, run_end, stream_end | valid & ready
// cfg       | in  | cfg_data[4:0] (group size)          | cfg_we high at clock edge
//
// Each accepted item is written to the group buffer; a group of n
// results is then read out with one buffer read each (one read port).
// Reset: fill count cleared, group size 1; the buffer is not cleared.
// Items stall while a group is read out; a stalled result holds the read port.
module group_order_reverser_unit #(
    parameter int MAX_GROUP = 16
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [grev_pkg::GS_W-1:0]   cfg_data,
    grev_in_if.sink                          items,
    grev_out_if.source                       results
);

    localparam int AW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
    localparam int CW = $clog2(MAX_GROUP + 1);

    logic                          mem_we;
    logic [AW-1:0]                 mem_waddr;
    logic                          mem_re;
    logic [AW-1:0]                 mem_raddr;
    logic [grev_pkg::VALUE_W-1:0]  mem_rdata;
    grev_pkg::status_t             status;

    // Sequencer
    grev_seq #(
        .MAX_GROUP (MAX_GROUP),
        .AW        (AW),
        .CW        (CW)
    ) u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_data       (cfg_data),
        .in_valid       (items.valid),
        .in_ready       (items.ready),
        .in_final       (items.final_item),
        .out_valid      (results.valid),
        .out_ready      (results.ready),
        .out_run_end    (results.run_end),
        .out_stream_end (results.stream_end),
        .mem_we         (mem_we),
        .mem_waddr      (mem_waddr),
        .mem_re         (mem_re),
        .mem_raddr      (mem_raddr),
        .status         (status)
    );

    // Group buffer
    grev_mem #(
        .DEPTH (MAX_GROUP),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (items.value),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign results.value_out = mem_rdata;

`ifndef NO_ASSERTIONS
    // Buffer reads only happen during a readout
    a_read_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
        status.rd_issue |-> status.emitting)
        else $error("buffer read outside readout");

    // Every issued read shows up as a result next cycle
    a_read_to_valid: assert property (@(posedge clk) disable iff (!rst_n)
        status.rd_issue |=> results.valid)
        else $error("read issued but no result presented");

    // End of stream is always the end of a run
    a_stream_run: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.stream_end) |-> results.run_end)
        else $error("stream_end without run_end");
`endif

endmodule : group_order_reverser_unit

`default_nettype wire
